// ===== src/ple_pkg.sv =====
// ple_pkg: shared types and codes for the positional list engine
// command modes, result status codes, control and status structs
// no dependencies
package ple_pkg;

    localparam int POS_W  = 6;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_GET    = 3'd2,
        MODE_SIZE   = 3'd3,
        MODE_DUMP   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OUT_RANGE,
        OUT_FULL,
        OUT_EMPTY,
        OUT_SIZE,
        OUT_READ
    } out_sel_t;

    typedef struct packed {
        logic     load_cmd;
        logic     do_insert;
        logic     do_remove;
        logic     rd_pos;
        logic     rd_first;
        logic     rd_next;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } ple_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  pos_gt_count;
        logic  pos_ge_count;
        logic  full;
        logic  empty;
        logic  dump_last;
        logic  out_free;
    } ple_stat_t;

endpackage

// ===== src/ple_ctrl.sv =====
// ple_ctrl: command sequencer for the positional list engine
// decodes the latched command and steps the datapath through it
// depends on ple_pkg
module ple_ctrl
    import ple_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  ple_stat_t stat,
    output ple_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   single_reg, single_next;

    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = OUT_READ;
        state_next  = state_reg;
        single_next = single_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.pos_gt_count || stat.full)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = stat.pos_gt_count ? OUT_RANGE : OUT_FULL;
                                cmd.out_last = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.do_insert = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (stat.pos_ge_count)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_RANGE;
                                cmd.out_last = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.do_remove = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    MODE_GET:
                    begin
                        if (stat.pos_ge_count)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_RANGE;
                                cmd.out_last = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_pos  = 1'b1;
                            single_next = 1'b1;
                            state_next  = S_EMIT;
                        end
                    end
                    MODE_SIZE:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_SIZE;
                            cmd.out_last = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_EMPTY;
                                cmd.out_last = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            single_next  = 1'b0;
                            state_next   = S_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_READ;
                    cmd.out_last = single_reg | stat.dump_last;
                    if (single_reg || stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            single_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            single_reg <= single_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== src/ple_datapath.sv =====
// ple_datapath: shifting entry cells, count, read register and output register
// executes the commands issued by ple_ctrl and reports list status
// depends on ple_pkg
module ple_datapath
    import ple_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               mode,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    input  ple_cmd_t                 cmd,
    output ple_stat_t                stat,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] data,
    output logic [1:0]               status,
    output logic                     last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    mode_t                       mode_reg;
    logic [POS_W-1:0]            pos_reg;
    logic signed [DATA_W-1:0]    value_reg;
    logic signed [WORD_BITS-1:0] word_in;
    logic signed [WORD_BITS-1:0] entries_reg [DEPTH];
    logic signed [WORD_BITS-1:0] rd_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            idx_inc;
    logic [IDX_W-1:0]            rd_addr;
    logic                        out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]    data_reg, data_next;
    status_t                     status_reg, status_next;
    logic                        last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_cmd)
        begin
            mode_reg  <= mode_t'(mode);
            pos_reg   <= position;
            value_reg <= value;
        end
    end

    assign word_in = WORD_BITS'(value_reg);

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [WORD_BITS-1:0] below_w;
        logic signed [WORD_BITS-1:0] above_w;

        if (g > 0)
        begin : g_below
            assign below_w = entries_reg[g-1];
        end
        else
        begin : g_first
            assign below_w = word_in;
        end

        if (g < DEPTH - 1)
        begin : g_above
            assign above_w = entries_reg[g+1];
        end
        else
        begin : g_top
            assign above_w = entries_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.do_insert)
            begin
                if (POS_W'(g) == pos_reg)
                begin
                    entries_reg[g] <= word_in;
                end
                else if (POS_W'(g) > pos_reg)
                begin
                    entries_reg[g] <= below_w;
                end
            end
            else if (cmd.do_remove)
            begin
                if (POS_W'(g) >= pos_reg)
                begin
                    entries_reg[g] <= above_w;
                end
            end
        end
    end

    assign idx_inc = IDX_W'(idx_reg + 1'b1);

    always_comb
    begin
        if (cmd.rd_pos)
        begin
            rd_addr = pos_reg[IDX_W-1:0];
        end
        else if (cmd.rd_first)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = idx_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_pos || cmd.rd_first || cmd.rd_next)
        begin
            rd_reg <= entries_reg[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.rd_first)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            idx_next = idx_inc;
        end
    end

    assign stat.mode         = mode_reg;
    assign stat.pos_gt_count = CMP_W'(pos_reg) > CMP_W'(count_reg);
    assign stat.pos_ge_count = CMP_W'(pos_reg) >= CMP_W'(count_reg);
    assign stat.full         = (count_reg == CNT_W'(DEPTH));
    assign stat.empty        = (count_reg == '0);
    assign stat.dump_last    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);

    always_comb
    begin
        case (cmd.out_sel)
            OUT_RANGE:
            begin
                data_next   = '0;
                status_next = STATUS_RANGE;
            end
            OUT_FULL:
            begin
                data_next   = '0;
                status_next = STATUS_FULL;
            end
            OUT_EMPTY:
            begin
                data_next   = '0;
                status_next = STATUS_EMPTY;
            end
            OUT_SIZE:
            begin
                data_next   = DATA_W'(count_reg);
                status_next = STATUS_OK;
            end
            OUT_READ:
            begin
                data_next   = DATA_W'(rd_reg);
                status_next = STATUS_OK;
            end
            default:
            begin
                data_next   = '0;
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count above depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> (count_reg != CNT_W'(DEPTH)) && !cmd.do_remove)
        else $error("insert into a full list");
`endif

endmodule

// ===== src/positional_list_engine.sv =====
// positional_list_engine: ordered list of signed words with positional edits
// insert/remove: accepted, executed next cycle, then back to idle for the next command
// get/size: one result, a get via the read register; dump: first entry read, then
// one entry per cycle unless output stalls, set by the entry cells' single read port
// error results for insert/remove are loaded from the execute state once output is free
// reset clears the count and output valid; entry cells are not cleared
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               mode,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] data,
    output logic [1:0]               status,
    output logic                     last
);

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ple_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .position  (position),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .status    (status),
        .last      (last)
    );

endmodule
